FILE: rtl/epg_pkg.sv
// ----------------------------------------------------------------------------
// epg_pkg
// shared types and constants of the event pattern grader
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package epg_pkg;

  // table size and derived widths
  localparam int unsigned MAX_PATTERNS = 32;
  localparam int unsigned IdxW  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_PATTERNS + 1);
  localparam int unsigned EntryW = 16;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;
  localparam logic [CfgIdxW-1:0] CFG_INVALID_GRADE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BORDER_INVALID = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LARGE_INVALID  = 2'd2;

  // command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_GRADE = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] pattern_mask;
    logic [7:0] pattern_grade;
    logic [7:0] charge_mask;
    logic       at_border;
    logic       is_large;
  } epg_in_t;

  typedef struct packed {
    logic signed [8:0] grade;
    logic              add_rejected;
  } epg_out_t;

endpackage

`default_nettype wire

FILE: rtl/epg_ram.sv
// ----------------------------------------------------------------------------
// epg_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epg_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/event_pattern_grader_top.sv
// ----------------------------------------------------------------------------
// event_pattern_grader_top
// grades a detector event by exact match of its neighbour mask in a table
// ----------------------------------------------------------------------------
// answers: an add, or a grade answered without a scan (policy or empty
//   table), comes in the next cycle; a scan answers once the entry that
//   matches is compared, or after the last stored entry with no match
// throughput: busy holds through the scan, so no new item is taken until a
//   scanned grade has answered; other items one per cycle while not busy
// reset: async active low; clears count, sequencer, done, config registers (invalid -1)
`timescale 1ns / 1ps
`default_nettype none

module event_pattern_grader_top (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire epg_pkg::epg_in_t         cmd_i,
  output logic                          done_o,
  output epg_pkg::epg_out_t             res_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [epg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [epg_pkg::CfgDataW-1:0] cfg_wdata_i
);

  import epg_pkg::*;

  // sequencer states
  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_SCAN = 1'b1;

  logic [0:0] state_q, state_d;

  // configuration registers
  logic signed [8:0] inv_grade_q;
  logic              border_inv_q;
  logic              large_inv_q;

  // table bookkeeping
  logic [CntW-1:0] count_q, count_d;

  // scan pointers: rd_idx is the address being read, cmp_idx the entry
  // whose data the ram shows this cycle
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic            pend_q, pend_d;
  logic [7:0]      mask_q, mask_d;

  // result register
  logic     done_q, done_d;
  epg_out_t res_q, res_d;

  // ram ports
  logic              ram_we;
  logic              ram_re;
  logic [EntryW-1:0] ram_wdata;
  logic [EntryW-1:0] ram_rdata;

  logic accept;
  logic table_full;
  logic policy_reject;
  logic entry_hit;
  logic last_entry;

  assign accept        = start && !busy;
  assign table_full    = (count_q == CntW'(MAX_PATTERNS));
  assign policy_reject = (cmd_i.is_large && large_inv_q) ||
                         (cmd_i.at_border && border_inv_q);
  assign entry_hit     = (ram_rdata[7:0] == mask_q);
  assign last_entry    = ({1'b0, cmp_idx_q} == (count_q - CntW'(1)));
  assign ram_wdata     = {cmd_i.pattern_grade, cmd_i.pattern_mask};

  // appends go to the slot at the current count
  assign ram_we = accept && (cmd_i.command == CMD_ADD) && !table_full;
  assign ram_re = (state_q == ST_SCAN);

  epg_ram #(
    .Width (EntryW),
    .Depth (MAX_PATTERNS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    cmp_idx_d = cmp_idx_q;
    pend_d    = pend_q;
    mask_d    = mask_q;
    done_d    = 1'b0;
    res_d     = res_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i.command == CMD_ADD) begin
            done_d             = 1'b1;
            res_d.grade        = '0;
            res_d.add_rejected = table_full;
            if (!table_full) begin
              count_d = count_q + CntW'(1);
            end
          end else if (policy_reject || (count_q == '0)) begin
            // no scan needed, answer straight away
            done_d             = 1'b1;
            res_d.grade        = inv_grade_q;
            res_d.add_rejected = 1'b0;
          end else begin
            state_d  = ST_SCAN;
            rd_idx_d = '0;
            pend_d   = 1'b0;
            mask_d   = cmd_i.charge_mask;
          end
        end
      end
      ST_SCAN: begin
        // issue the next read; stop advancing at the last slot
        cmp_idx_d = rd_idx_q;
        pend_d    = 1'b1;
        if (rd_idx_q != IdxW'(MAX_PATTERNS - 1)) begin
          rd_idx_d = rd_idx_q + IdxW'(1);
        end
        if (pend_q) begin
          if (entry_hit || last_entry) begin
            state_d            = ST_IDLE;
            done_d             = 1'b1;
            res_d.add_rejected = 1'b0;
            res_d.grade        = entry_hit ? $signed({1'b0, ram_rdata[15:8]}) : inv_grade_q;
            pend_d             = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  // configuration, unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_grade_q  <= -9'sd1;
      border_inv_q <= 1'b0;
      large_inv_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INVALID_GRADE:  inv_grade_q  <= $signed(cfg_wdata_i);
        CFG_BORDER_INVALID: border_inv_q <= cfg_wdata_i[0];
        CFG_LARGE_INVALID:  large_inv_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= cmp_idx_d;
    mask_q    <= mask_d;
    res_q     <= res_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

FILE: rtl/event_pattern_grader_chk.sv
// ----------------------------------------------------------------------------
// event_pattern_grader_chk
// port level checks of the event pattern grader, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module event_pattern_grader_chk (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     start,
  input wire logic                     busy,
  input wire epg_pkg::epg_in_t         cmd_i,
  input wire logic                     done_o,
  input wire epg_pkg::epg_out_t        res_o
);

  import epg_pkg::*;

  // an accepted item either answers next cycle or starts a scan
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted item neither answered nor scanning");

  // a result is only shown once the block has gone idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  // results only follow an accepted item or a running scan
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) || $past(start && !busy)))
    else $error("result without an item");

  // a rejected add carries a zero grade
  a_reject_grade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.add_rejected) |-> (res_o.grade == 9'sd0))
    else $error("rejected add with nonzero grade");

  // an accepted add answers next cycle with a zero grade
  a_add_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i.command == CMD_ADD) |=> (done_o && res_o.grade == 9'sd0))
    else $error("add not answered with a zero grade");

endmodule

bind event_pattern_grader_top event_pattern_grader_chk u_chk (.*);

`default_nettype wire
